// ----- sv/rv64im_instruction_decoder_top_defines.svh -----
// Assertion macros used by the decoder's checker file.
`ifndef RV64IM_INSTRUCTION_DECODER_TOP_DEFINES_SVH
`define RV64IM_INSTRUCTION_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RVD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rvd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RVD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rvd assertion failed");

`endif

// ----- sv/rvd_pkg.sv -----
// Package: opcodes, function codes, formats and payload types of the decoder.
package rvd_pkg;

	localparam int INSTR_W = 32;
	localparam int XLEN    = 64;

	localparam logic [6:0] OPC_OP      = 7'h33;
	localparam logic [6:0] OPC_OP32    = 7'h3B;
	localparam logic [6:0] OPC_LOAD    = 7'h03;
	localparam logic [6:0] OPC_OPIMM   = 7'h13;
	localparam logic [6:0] OPC_JALR    = 7'h67;
	localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
	localparam logic [6:0] OPC_STORE   = 7'h23;
	localparam logic [6:0] OPC_BRANCH  = 7'h63;
	localparam logic [6:0] OPC_LUI     = 7'h37;
	localparam logic [6:0] OPC_AUIPC   = 7'h17;
	localparam logic [6:0] OPC_JAL     = 7'h6F;
	localparam logic [6:0] OPC_SYSTEM  = 7'h73;

	localparam logic [2:0] FMT_NONE = 3'd0;
	localparam logic [2:0] FMT_R    = 3'd1;
	localparam logic [2:0] FMT_I    = 3'd2;
	localparam logic [2:0] FMT_S    = 3'd3;
	localparam logic [2:0] FMT_B    = 3'd4;
	localparam logic [2:0] FMT_U    = 3'd5;
	localparam logic [2:0] FMT_J    = 3'd6;
	localparam logic [2:0] FMT_SYS  = 3'd7;

	localparam logic [6:0] F7_BASE   = 7'h00;
	localparam logic [6:0] F7_MULDIV = 7'h01;
	localparam logic [6:0] F7_ALT    = 7'h20;
	localparam logic [5:0] F6_BASE   = 6'h00;
	localparam logic [5:0] F6_ALT    = 6'h10;

	localparam logic [2:0] F3_ADD     = 3'd0;
	localparam logic [2:0] F3_SLL     = 3'd1;
	localparam logic [2:0] F3_BR_RSV2 = 3'd2;
	localparam logic [2:0] F3_BR_RSV3 = 3'd3;
	localparam logic [2:0] F3_DIV     = 3'd4;
	localparam logic [2:0] F3_SR      = 3'd5;
	localparam logic [2:0] F3_LD_RSV  = 3'd7;
	localparam logic [2:0] F3_ST_MAX  = 3'd3;
	localparam logic [2:0] F3_PRIV    = 3'd0;
	localparam logic [2:0] F3_CSR_RSV = 3'd4;

	localparam logic [11:0] F12_ECALL  = 12'h000;
	localparam logic [11:0] F12_EBREAK = 12'h001;
	localparam logic [11:0] F12_MRET   = 12'h302;
	localparam logic [11:0] F12_WFI    = 12'h105;

	localparam logic [4:0] REG_ZERO      = 5'd0;
	localparam logic [1:0] CAUSE_NONE    = 2'd0;
	localparam logic [1:0] CAUSE_ILLEGAL = 2'd2;

	typedef struct packed {
		logic [INSTR_W-1:0] instr;
		logic [2:0]         fmt;
		logic               ok;
	} cls_t;

	typedef struct packed {
		logic [4:0]             rs1;
		logic [4:0]             rs2;
		logic [4:0]             rd;
		logic [6:0]             opcode;
		logic [2:0]             func3;
		logic [11:0]            func12;
		logic [11:0]            csr_address;
		logic [2:0]             format;
		logic signed [XLEN-1:0] immediate;
		logic                   illegal;
		logic [1:0]             exc_cause;
	} dec_t;

endpackage

// ----- sv/rvd_if.sv -----
// Channel interfaces: instruction beats in, decoded beats out.
interface rvd_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr;

	modport source (output valid, output instr, input ready);
	modport sink   (input valid, input instr, output ready);
endinterface

interface rvd_out_if;
	logic               valid;
	logic               ready;
	logic [4:0]         rs1;
	logic [4:0]         rs2;
	logic [4:0]         rd;
	logic [6:0]         opcode;
	logic [2:0]         func3;
	logic [11:0]        func12;
	logic [11:0]        csr_address;
	logic [2:0]         format;
	logic signed [63:0] immediate;
	logic               illegal;
	logic [1:0]         exc_cause;

	modport source (output valid, output rs1, output rs2, output rd, output opcode,
		output func3, output func12, output csr_address, output format,
		output immediate, output illegal, output exc_cause, input ready);
	modport sink   (input valid, input rs1, input rs2, input rd, input opcode,
		input func3, input func12, input csr_address, input format,
		input immediate, input illegal, input exc_cause, output ready);
endinterface

// ----- sv/rvd_classify.sv -----
// Stages 1 and 2: capture the instruction word, then classify format and check legality.
module rvd_classify (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [31:0]          in_instr,
	output logic                 in_ready,
	output logic                 out_valid,
	output rvd_pkg::cls_t        out_cls,
	input  logic                 out_ready
);
	import rvd_pkg::*;

	logic [INSTR_W-1:0] instr_s1;
	logic               valid_s1;
	logic               valid_s2;
	cls_t               cls_s2;
	logic               ready_s1;
	logic               ready_s2;

	logic [6:0]  op;
	logic [2:0]  f3;
	logic [11:0] f12;
	logic [6:0]  f7;
	logic [5:0]  f6;
	logic [2:0]  fmt;
	logic        ok;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			instr_s1 <= in_instr;
		end
	end

	assign op  = instr_s1[6:0];
	assign f3  = instr_s1[14:12];
	assign f12 = instr_s1[31:20];
	assign f7  = instr_s1[31:25];
	assign f6  = instr_s1[31:26];

	always_comb begin
		fmt = FMT_NONE;
		ok  = 1'b0;
		unique case (op) inside
			OPC_OP: begin
				fmt = FMT_R;
				ok  = (f7 == F7_BASE) || (f7 == F7_MULDIV) ||
					((f7 == F7_ALT) && ((f3 == F3_ADD) || (f3 == F3_SR)));
			end
			OPC_OP32: begin
				fmt = FMT_R;
				if (f7 == F7_BASE) begin
					ok = (f3 == F3_ADD) || (f3 == F3_SLL) || (f3 == F3_SR);
				end else if (f7 == F7_MULDIV) begin
					ok = (f3 == F3_ADD) || (f3 >= F3_DIV);
				end else if (f7 == F7_ALT) begin
					ok = (f3 == F3_ADD) || (f3 == F3_SR);
				end
			end
			OPC_LOAD: begin
				fmt = FMT_I;
				ok  = (f3 != F3_LD_RSV);
			end
			OPC_OPIMM: begin
				fmt = FMT_I;
				if (f3 == F3_SLL) begin
					ok = (f6 == F6_BASE);
				end else if (f3 == F3_SR) begin
					ok = (f6 == F6_BASE) || (f6 == F6_ALT);
				end else begin
					ok = 1'b1;
				end
			end
			OPC_JALR: begin
				fmt = FMT_I;
				ok  = (f3 == F3_ADD);
			end
			OPC_OPIMM32: begin
				fmt = FMT_I;
				if (f3 == F3_ADD) begin
					ok = 1'b1;
				end else if (f3 == F3_SLL) begin
					ok = (f7 == F7_BASE);
				end else if (f3 == F3_SR) begin
					ok = (f7 == F7_BASE) || (f7 == F7_ALT);
				end
			end
			OPC_STORE: begin
				fmt = FMT_S;
				ok  = (f3 <= F3_ST_MAX);
			end
			OPC_BRANCH: begin
				fmt = FMT_B;
				ok  = !((f3 == F3_BR_RSV2) || (f3 == F3_BR_RSV3));
			end
			OPC_LUI, OPC_AUIPC: begin
				fmt = FMT_U;
				ok  = 1'b1;
			end
			OPC_JAL: begin
				fmt = FMT_J;
				ok  = 1'b1;
			end
			OPC_SYSTEM: begin
				fmt = FMT_SYS;
				if (f3 == F3_PRIV) begin
					ok = ((f12 == F12_ECALL) || (f12 == F12_EBREAK) ||
						(f12 == F12_MRET) || (f12 == F12_WFI)) &&
						(instr_s1[19:15] == REG_ZERO) && (instr_s1[11:7] == REG_ZERO);
				end else begin
					ok = (f3 != F3_CSR_RSV);
				end
			end
			default: begin
				fmt = FMT_NONE;
				ok  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			cls_s2.instr <= instr_s1;
			cls_s2.fmt   <= fmt;
			cls_s2.ok    <= ok;
		end
	end

	assign out_valid = valid_s2;
	assign out_cls   = cls_s2;

endmodule

// ----- sv/rvd_assemble.sv -----
// Stage 3: immediate build, register masking and the output register.
module rvd_assemble (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  rvd_pkg::cls_t  in_cls,
	output logic           in_ready,
	output logic           out_valid,
	output rvd_pkg::dec_t  out_dec,
	input  logic           out_ready
);
	import rvd_pkg::*;

	logic               valid_s3;
	dec_t               dec_s3;
	dec_t               dec;
	logic               ready_s3;
	logic [INSTR_W-1:0] w;

	assign ready_s3 = !valid_s3 || out_ready;
	assign in_ready = ready_s3;
	assign w        = in_cls.instr;

	always_comb begin
		dec.rs1         = w[19:15];
		dec.rs2         = w[24:20];
		dec.rd          = w[11:7];
		dec.opcode      = w[6:0];
		dec.func3       = w[14:12];
		dec.func12      = w[31:20];
		dec.csr_address = 12'd0;
		dec.format      = in_cls.fmt;
		dec.immediate   = '0;
		dec.illegal     = !in_cls.ok;
		dec.exc_cause   = in_cls.ok ? CAUSE_NONE : CAUSE_ILLEGAL;
		unique case (in_cls.fmt)
			FMT_R: begin
			end
			FMT_I: begin
				dec.rs2       = REG_ZERO;
				dec.immediate = {{52{w[31]}}, w[31:20]};
			end
			FMT_S: begin
				dec.rd        = REG_ZERO;
				dec.immediate = {{52{w[31]}}, w[31:25], w[11:7]};
			end
			FMT_B: begin
				dec.rd        = REG_ZERO;
				dec.immediate = {{52{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
			end
			FMT_U: begin
				dec.rs1       = REG_ZERO;
				dec.rs2       = REG_ZERO;
				dec.immediate = {{32{w[31]}}, w[31:12], 12'd0};
			end
			FMT_J: begin
				dec.rs1       = REG_ZERO;
				dec.rs2       = REG_ZERO;
				dec.immediate = {{44{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
			end
			FMT_SYS: begin
				dec.rs2         = REG_ZERO;
				dec.csr_address = w[31:20];
				dec.immediate   = {59'd0, w[19:15]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			dec_s3 <= dec;
		end
	end

	assign out_valid = valid_s3;
	assign out_dec   = dec_s3;

endmodule

// ----- sv/rv64im_instruction_decoder_top.sv -----
// Top level of the RV64IM instruction decoder.
//
// src carries one 32-bit instruction word per beat; dst carries one decoded
// beat per instruction: register indices, opcode, funct3, funct12, CSR
// address, format code, 64-bit immediate and the illegal flag with cause.
// Both channels use valid/ready; a beat moves on a clock edge where both
// are high.
// Path: a taken beat goes through the input capture register, then the
// classify/legality register, then the immediate/output register.
// Throughput: one beat per cycle while dst.ready is high; the three
// registered stages hold one instruction each and can all be full.
// Stall: when dst.ready is low the output beat holds and the stages behind
// it fill; src.ready drops only once every stage holds a beat. Nothing is
// dropped or repeated.
// Reset: arst_n clears all stage valid bits at once; the block accepts a
// beat as soon as reset is released.
module rv64im_instruction_decoder_top (
	input  logic     clk,
	input  logic     arst_n,
	rvd_in_if.sink   src,
	rvd_out_if.source dst
);
	import rvd_pkg::*;

	logic cls_valid;
	logic cls_ready;
	cls_t cls;
	dec_t dec;

	rvd_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (src.valid),
		.in_instr  (src.instr),
		.in_ready  (src.ready),
		.out_valid (cls_valid),
		.out_cls   (cls),
		.out_ready (cls_ready)
	);

	rvd_assemble u_assemble (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cls_valid),
		.in_cls    (cls),
		.in_ready  (cls_ready),
		.out_valid (dst.valid),
		.out_dec   (dec),
		.out_ready (dst.ready)
	);

	assign dst.rs1         = dec.rs1;
	assign dst.rs2         = dec.rs2;
	assign dst.rd          = dec.rd;
	assign dst.opcode      = dec.opcode;
	assign dst.func3       = dec.func3;
	assign dst.func12      = dec.func12;
	assign dst.csr_address = dec.csr_address;
	assign dst.format      = dec.format;
	assign dst.immediate   = dec.immediate;
	assign dst.illegal     = dec.illegal;
	assign dst.exc_cause   = dec.exc_cause;

endmodule

// ----- sv/rvd_check.sv -----
// Port-level checker for the decoder, bound to the top level.
`include "rv64im_instruction_decoder_top_defines.svh"

module rvd_check (
	input logic               clk,
	input logic               arst_n,
	input logic               dst_valid,
	input logic               dst_ready,
	input logic [4:0]         rs1,
	input logic [4:0]         rs2,
	input logic [4:0]         rd,
	input logic [2:0]         format,
	input logic [11:0]        csr_address,
	input logic signed [63:0] immediate,
	input logic               illegal,
	input logic [1:0]         exc_cause
);
	import rvd_pkg::*;

	`RVD_ASSERT_IMPLY(a_cause_matches, clk, arst_n, dst_valid, (illegal && exc_cause == CAUSE_ILLEGAL) || (!illegal && exc_cause == CAUSE_NONE))
	`RVD_ASSERT_IMPLY(a_uj_no_src, clk, arst_n, dst_valid && (format == FMT_U || format == FMT_J), rs1 == REG_ZERO && rs2 == REG_ZERO)
	`RVD_ASSERT_IMPLY(a_sb_no_rd, clk, arst_n, dst_valid && (format == FMT_S || format == FMT_B), rd == REG_ZERO)
	`RVD_ASSERT_IMPLY(a_csr_only_sys, clk, arst_n, dst_valid && format != FMT_SYS, csr_address == 12'd0)
	`RVD_ASSERT_NEXT(a_stall_hold, clk, arst_n, dst_valid && !dst_ready, dst_valid && $stable(immediate) && $stable(format))

endmodule

bind rv64im_instruction_decoder_top rvd_check u_rvd_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.dst_valid   (dst.valid),
	.dst_ready   (dst.ready),
	.rs1         (dst.rs1),
	.rs2         (dst.rs2),
	.rd          (dst.rd),
	.format      (dst.format),
	.csr_address (dst.csr_address),
	.immediate   (dst.immediate),
	.illegal     (dst.illegal),
	.exc_cause   (dst.exc_cause)
);
